### hw/rtl/odo_pkg.sv
package odo_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WL_MUL1,
        ST_WL_MUL2,
        ST_WL_DIV1,
        ST_WL_MUL3,
        ST_WL_DIV2,
        ST_X_MUL,
        ST_Y_MUL,
        ST_H_MUL,
        ST_H_DIV,
        ST_OUT
    } odo_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } odo_unit_st_t;

    localparam int MUL_A_W = 64;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int DIV_N_W = 64;
    localparam int DIV_D_W = 32;
    localparam int ACC_W   = 48;
    localparam int TRIG_W  = 34;
    localparam int ATAN_N  = 24;

    localparam logic [2:0] CFG_PERIOD   = 3'd0;
    localparam logic [2:0] CFG_DIAMETER = 3'd1;
    localparam logic [2:0] CFG_BASE     = 3'd2;
    localparam logic [2:0] CFG_LREV     = 3'd3;
    localparam logic [2:0] CFG_RREV     = 3'd4;

    localparam logic [19:0] PERIOD_RST   = 20'd50000;
    localparam logic [19:0] DIAMETER_RST = 20'd65000;
    localparam logic [20:0] BASE_RST     = 21'd150000;

    localparam logic [MUL_B_W-1:0] PI_Q20    = 32'd3294199;
    localparam logic [MUL_B_W-1:0] INVPI_Q20 = 32'd333772;
    localparam logic [DIV_D_W-1:0] V_DEN     = 32'd62914560;
    localparam logic [DIV_N_W-1:0] V_HALF    = 64'd31457280;
    localparam logic [DIV_D_W-1:0] D_DEN     = 32'd1000000;
    localparam logic [DIV_N_W-1:0] D_HALF    = 64'd500000;
    localparam logic [MUL_P_W-1:0] RND_Q31   = 96'h4000_0000;
    localparam logic signed [TRIG_W-1:0] GAIN_Q30 = 34'sd652032874;

    function automatic logic [31:0] atan_at(input logic [4:0] idx);
        logic [31:0] r;
        case (idx)
            5'd0:    r = 32'd536870912;
            5'd1:    r = 32'd316933406;
            5'd2:    r = 32'd167458907;
            5'd3:    r = 32'd85004756;
            5'd4:    r = 32'd42667331;
            5'd5:    r = 32'd21354465;
            5'd6:    r = 32'd10679838;
            5'd7:    r = 32'd5340245;
            5'd8:    r = 32'd2670163;
            5'd9:    r = 32'd1335087;
            5'd10:   r = 32'd667544;
            5'd11:   r = 32'd333772;
            5'd12:   r = 32'd166886;
            5'd13:   r = 32'd83443;
            5'd14:   r = 32'd41722;
            5'd15:   r = 32'd20861;
            5'd16:   r = 32'd10430;
            5'd17:   r = 32'd5215;
            5'd18:   r = 32'd2608;
            5'd19:   r = 32'd1304;
            5'd20:   r = 32'd652;
            5'd21:   r = 32'd326;
            5'd22:   r = 32'd163;
            5'd23:   r = 32'd81;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                 input logic [ACC_W-1:0] d);
        logic [ACC_W:0] s;
        logic [ACC_W-1:0] r;
        s = {a[ACC_W-1], a} + {d[ACC_W-1], d};
        if (s[ACC_W] != s[ACC_W-1])
        begin
            r = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            r = s[ACC_W-1:0];
        end
        return r;
    endfunction

endpackage

### hw/rtl/odo_mul.sv
module odo_mul import odo_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [MUL_A_W-1:0] a,
    input  logic [MUL_B_W-1:0] b,
    output logic [MUL_P_W-1:0] p,
    output odo_unit_st_t       st
);

    logic [MUL_P_W-1:0] acc_reg, acc_next;
    logic [MUL_P_W-1:0] ash_reg, ash_next;
    logic [MUL_B_W-1:0] bsh_reg, bsh_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    // One bit of the multiplier operand is consumed per cycle.
    always_comb
    begin
        acc_next  = acc_reg;
        ash_next  = ash_reg;
        bsh_next  = bsh_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            ash_next  = {{MUL_B_W{1'b0}}, a};
            bsh_next  = b;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = acc_reg + (bsh_reg[0] ? ash_reg : '0);
            ash_next = {ash_reg[MUL_P_W-2:0], 1'b0};
            bsh_next = {1'b0, bsh_reg[MUL_B_W-1:1]};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(MUL_B_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        ash_reg <= ash_next;
        bsh_reg <= bsh_next;
    end

    assign p       = acc_reg;
    assign st.busy = busy_reg;
    assign st.done = done_reg;

endmodule

### hw/rtl/odo_div.sv
module odo_div import odo_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_N_W-1:0] num,
    input  logic [DIV_D_W-1:0] den,
    output logic [DIV_N_W-1:0] quo,
    output odo_unit_st_t       st
);

    logic [DIV_N_W-1:0] nsh_reg, nsh_next;
    logic [DIV_D_W-1:0] rem_reg, rem_next;
    logic [DIV_D_W-1:0] den_reg, den_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [DIV_D_W:0]   trial;
    logic [DIV_D_W+1:0] diff;

    // Restoring division, one quotient bit per cycle; the quotient shifts
    // into the numerator register as the numerator shifts out.
    assign trial = {rem_reg, nsh_reg[DIV_N_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, den_reg};

    always_comb
    begin
        nsh_next  = nsh_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            nsh_next  = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (diff[DIV_D_W+1])
            begin
                rem_next = trial[DIV_D_W-1:0];
                nsh_next = {nsh_reg[DIV_N_W-2:0], 1'b0};
            end
            else
            begin
                rem_next = diff[DIV_D_W-1:0];
                nsh_next = {nsh_reg[DIV_N_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(DIV_N_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nsh_reg <= nsh_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quo     = nsh_reg;
    assign st.busy = busy_reg;
    assign st.done = done_reg;

endmodule

### hw/rtl/odo_cordic.sv
module odo_cordic import odo_pkg::*;
#(
    parameter int ANGLE_BITS = 16,
    parameter int TRIG_STEPS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [31:0]              angle,
    output logic                     valid,
    output logic signed [TRIG_W-1:0] cos_q30,
    output logic signed [TRIG_W-1:0] sin_q30
);

    localparam int NSTEPS = (TRIG_STEPS < ATAN_N) ? TRIG_STEPS : ATAN_N;
    localparam logic [31:0] ANG_MASK = {{ANGLE_BITS{1'b1}}, {(32 - ANGLE_BITS){1'b0}}};

    logic signed [TRIG_W-1:0] x_reg, x_next;
    logic signed [TRIG_W-1:0] y_reg, y_next;
    logic signed [TRIG_W-1:0] z_reg, z_next;
    logic signed [TRIG_W-1:0] c_reg, c_next;
    logic signed [TRIG_W-1:0] s_reg, s_next;
    logic                     flip_reg, flip_next;
    logic [4:0]               cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic                     valid_reg, valid_next;
    logic [31:0]              u_cut;
    logic [31:0]              u_rot;
    logic                     flip;
    logic signed [TRIG_W-1:0] xs;
    logic signed [TRIG_W-1:0] ys;
    logic signed [TRIG_W-1:0] at;

    // Angles in the left half plane are turned by pi and the results negated.
    assign u_cut = angle & ANG_MASK;
    assign flip  = u_cut[31] ^ u_cut[30];
    assign u_rot = flip ? (u_cut + 32'h8000_0000) : u_cut;
    assign xs    = x_reg >>> cnt_reg;
    assign ys    = y_reg >>> cnt_reg;
    assign at    = $signed({2'b00, atan_at(cnt_reg)});

    always_comb
    begin
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        c_next     = c_reg;
        s_next     = s_reg;
        flip_next  = flip_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        valid_next = valid_reg;
        if (start)
        begin
            x_next     = GAIN_Q30;
            y_next     = '0;
            z_next     = $signed({{(TRIG_W - 32){u_rot[31]}}, u_rot});
            flip_next  = flip;
            cnt_next   = '0;
            busy_next  = 1'b1;
            valid_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (!z_reg[TRIG_W-1])
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - at;
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + at;
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(NSTEPS - 1))
            begin
                busy_next  = 1'b0;
                valid_next = 1'b1;
                c_next     = flip_reg ? -x_next : x_next;
                s_next     = flip_reg ? -y_next : y_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        c_reg    <= c_next;
        s_reg    <= s_next;
        flip_reg <= flip_next;
    end

    assign valid   = valid_reg;
    assign cos_q30 = c_reg;
    assign sin_q30 = s_reg;

endmodule

### hw/rtl/diff_drive_odometry.sv
// Channel   Direction  Beat contents
// s_*       in         tuser: kind; tdata: left_speed, right_speed
// m_*       out        tdata: pos_x_um, pos_y_um, heading, left_dist_um, right_dist_um
// cfg_*     in         cfg_index selects the register, cfg_data carries its value
//
// A tick beat is worked out by fourteen operations on the bit-serial multiplier
// and the restoring divider. A pose reset beat goes straight to the output state.
// One beat is worked on at a time, and the next beat is taken only once the result
// is loaded. After reset the pose is zero and the registers hold their default
// values. A stalled result waits in the output register; the next beat is then
// taken but its result waits until the previous one has gone.
module diff_drive_odometry import odo_pkg::*;
#(
    parameter int ANGLE_BITS = 16,
    parameter int TRIG_STEPS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,   // left_speed, right_speed, zero fill
    input  logic         s_tuser,   // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,   // pos_x_um, pos_y_um, heading, left_dist_um, right_dist_um
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [20:0]  cfg_data
);

    odo_state_t         state_reg, state_next;
    logic               started_reg, started_next;
    logic               side_reg, side_next;
    logic [18:0]        lsp_reg, lsp_next;
    logic [18:0]        rsp_reg, rsp_next;
    logic [63:0]        work_reg, work_next;
    logic [ACC_W-1:0]   dl_reg, dl_next;
    logic [ACC_W-1:0]   dr_reg, dr_next;
    logic [ACC_W-1:0]   xacc_reg, xacc_next;
    logic [ACC_W-1:0]   yacc_reg, yacc_next;
    logic [ACC_W-1:0]   lacc_reg, lacc_next;
    logic [ACC_W-1:0]   racc_reg, racc_next;
    logic [31:0]        head_reg, head_next;
    logic               oval_reg, oval_next;
    logic [143:0]       odata_reg, odata_next;

    logic [19:0]        period_reg;
    logic [19:0]        diam_reg;
    logic [20:0]        base_reg;
    logic               lrev_reg;
    logic               rrev_reg;

    logic               mul_start;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_p;
    odo_unit_st_t       mul_st;
    logic               div_start;
    logic [DIV_N_W-1:0] div_num;
    logic [DIV_D_W-1:0] div_den;
    logic [DIV_N_W-1:0] div_q;
    odo_unit_st_t       div_st;
    logic               trig_start;
    logic               trig_valid;
    logic signed [TRIG_W-1:0] cos_q30;
    logic signed [TRIG_W-1:0] sin_q30;

    logic [18:0]        spd;
    logic               rev;
    logic [19:0]        s_ext;
    logic [19:0]        s_dir;
    logic               s_neg;
    logic [19:0]        s_mag;
    logic [ACC_W-1:0]   sum_lr;
    logic [ACC_W-1:0]   sum_mag;
    logic [ACC_W-1:0]   dif_lr;
    logic [ACC_W-1:0]   dif_mag;
    logic [TRIG_W-1:0]  cos_mag;
    logic [TRIG_W-1:0]  sin_mag;
    logic [MUL_P_W-1:0] p_rnd;
    logic [ACC_W-1:0]   q31_mag;
    logic [20:0]        base_eff;
    logic [ACC_W-1:0]   dmag;

    odo_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .p     (mul_p),
        .st    (mul_st)
    );

    odo_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_q),
        .st    (div_st)
    );

    odo_cordic #(
        .ANGLE_BITS (ANGLE_BITS),
        .TRIG_STEPS (TRIG_STEPS)
    ) u_cordic
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (trig_start),
        .angle   (head_reg),
        .valid   (trig_valid),
        .cos_q30 (cos_q30),
        .sin_q30 (sin_q30)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RST;
            diam_reg   <= DIAMETER_RST;
            base_reg   <= BASE_RST;
            lrev_reg   <= 1'b1;
            rrev_reg   <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PERIOD:   period_reg <= cfg_data[19:0];
                CFG_DIAMETER: diam_reg   <= cfg_data[19:0];
                CFG_BASE:     base_reg   <= cfg_data;
                CFG_LREV:     lrev_reg   <= cfg_data[0];
                CFG_RREV:     rrev_reg   <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    assign spd     = side_reg ? rsp_reg : lsp_reg;
    assign rev     = side_reg ? rrev_reg : lrev_reg;
    assign s_ext   = {spd[18], spd};
    assign s_dir   = rev ? (20'd0 - s_ext) : s_ext;
    assign s_neg   = s_dir[19];
    assign s_mag   = s_neg ? (20'd0 - s_dir) : s_dir;
    assign sum_lr  = dl_reg + dr_reg;
    assign sum_mag = sum_lr[ACC_W-1] ? ('0 - sum_lr) : sum_lr;
    assign dif_lr  = dr_reg - dl_reg;
    assign dif_mag = dif_lr[ACC_W-1] ? ('0 - dif_lr) : dif_lr;
    assign cos_mag = cos_q30[TRIG_W-1] ? ('0 - cos_q30) : cos_q30;
    assign sin_mag = sin_q30[TRIG_W-1] ? ('0 - sin_q30) : sin_q30;
    assign p_rnd   = mul_p + RND_Q31;
    assign q31_mag = p_rnd[ACC_W+30:31];
    assign base_eff = (base_reg == '0) ? 21'd1 : base_reg;
    assign dmag    = div_q[ACC_W-1:0];
    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        started_next = started_reg;
        side_next    = side_reg;
        lsp_next     = lsp_reg;
        rsp_next     = rsp_reg;
        work_next    = work_reg;
        dl_next      = dl_reg;
        dr_next      = dr_reg;
        xacc_next    = xacc_reg;
        yacc_next    = yacc_reg;
        lacc_next    = lacc_reg;
        racc_next    = racc_reg;
        head_next    = head_reg;
        oval_next    = oval_reg & ~m_tready;
        odata_next   = odata_reg;
        mul_start    = 1'b0;
        mul_a        = work_reg;
        mul_b        = '0;
        div_start    = 1'b0;
        div_num      = work_reg;
        div_den      = '0;
        trig_start   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                started_next = 1'b0;
                if (s_tvalid)
                begin
                    if (s_tuser)
                    begin
                        xacc_next  = '0;
                        yacc_next  = '0;
                        lacc_next  = '0;
                        racc_next  = '0;
                        head_next  = '0;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        lsp_next   = s_tdata[18:0];
                        rsp_next   = s_tdata[37:19];
                        side_next  = 1'b0;
                        trig_start = 1'b1;
                        state_next = ST_WL_MUL1;
                    end
                end
            end
            ST_WL_MUL1:
            begin
                mul_a = {44'd0, s_mag};
                mul_b = {12'd0, diam_reg};
                if (!started_reg)
                begin
                    mul_start    = 1'b1;
                    started_next = 1'b1;
                end
                else if (mul_st.done)
                begin
                    work_next    = mul_p[63:0];
                    started_next = 1'b0;
                    state_next   = ST_WL_MUL2;
                end
            end
            ST_WL_MUL2:
            begin
                mul_b = PI_Q20;
                if (!started_reg)
                begin
                    mul_start    = 1'b1;
                    started_next = 1'b1;
                end
                else if (mul_st.done)
                begin
                    work_next    = mul_p[63:0];
                    started_next = 1'b0;
                    state_next   = ST_WL_DIV1;
                end
            end
            ST_WL_DIV1:
            begin
                div_num = work_reg + V_HALF;
                div_den = V_DEN;
                if (!started_reg)
                begin
                    div_start    = 1'b1;
                    started_next = 1'b1;
                end
                else if (div_st.done)
                begin
                    work_next    = div_q;
                    started_next = 1'b0;
                    state_next   = ST_WL_MUL3;
                end
            end
            ST_WL_MUL3:
            begin
                mul_b = {12'd0, period_reg};
                if (!started_reg)
                begin
                    mul_start    = 1'b1;
                    started_next = 1'b1;
                end
                else if (mul_st.done)
                begin
                    work_next    = {mul_p[55:0], 8'd0};
                    started_next = 1'b0;
                    state_next   = ST_WL_DIV2;
                end
            end
            ST_WL_DIV2:
            begin
                div_num = work_reg + D_HALF;
                div_den = D_DEN;
                if (!started_reg)
                begin
                    div_start    = 1'b1;
                    started_next = 1'b1;
                end
                else if (div_st.done)
                begin
                    started_next = 1'b0;
                    if (!side_reg)
                    begin
                        dl_next    = s_neg ? ('0 - dmag) : dmag;
                        lacc_next  = sat_add(lacc_reg, dl_next);
                        side_next  = 1'b1;
                        state_next = ST_WL_MUL1;
                    end
                    else
                    begin
                        dr_next    = s_neg ? ('0 - dmag) : dmag;
                        racc_next  = sat_add(racc_reg, dr_next);
                        state_next = ST_X_MUL;
                    end
                end
            end
            ST_X_MUL:
            begin
                mul_a = {16'd0, sum_mag};
                mul_b = cos_mag[31:0];
                if (!started_reg)
                begin
                    if (trig_valid)
                    begin
                        mul_start    = 1'b1;
                        started_next = 1'b1;
                    end
                end
                else if (mul_st.done)
                begin
                    xacc_next = sat_add(xacc_reg, (sum_lr[ACC_W-1] ^ cos_q30[TRIG_W-1])
                                                  ? ('0 - q31_mag) : q31_mag);
                    started_next = 1'b0;
                    state_next   = ST_Y_MUL;
                end
            end
            ST_Y_MUL:
            begin
                mul_a = {16'd0, sum_mag};
                mul_b = sin_mag[31:0];
                if (!started_reg)
                begin
                    mul_start    = 1'b1;
                    started_next = 1'b1;
                end
                else if (mul_st.done)
                begin
                    yacc_next = sat_add(yacc_reg, (sum_lr[ACC_W-1] ^ sin_q30[TRIG_W-1])
                                                  ? ('0 - q31_mag) : q31_mag);
                    started_next = 1'b0;
                    state_next   = ST_H_MUL;
                end
            end
            ST_H_MUL:
            begin
                mul_a = {16'd0, dif_mag};
                mul_b = INVPI_Q20;
                if (!started_reg)
                begin
                    mul_start    = 1'b1;
                    started_next = 1'b1;
                end
                else if (mul_st.done)
                begin
                    work_next    = mul_p[63:0];
                    started_next = 1'b0;
                    state_next   = ST_H_DIV;
                end
            end
            ST_H_DIV:
            begin
                div_num = work_reg + {39'd0, base_eff, 4'd0};
                div_den = {6'd0, base_eff, 5'd0};
                if (!started_reg)
                begin
                    div_start    = 1'b1;
                    started_next = 1'b1;
                end
                else if (div_st.done)
                begin
                    head_next = dif_lr[ACC_W-1] ? (head_reg - div_q[31:0])
                                                : (head_reg + div_q[31:0]);
                    started_next = 1'b0;
                    state_next   = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!oval_reg || m_tready)
                begin
                    oval_next  = 1'b1;
                    odata_next = {racc_reg[47:16], lacc_reg[47:16], head_reg[31:16],
                                  yacc_reg[47:16], xacc_reg[47:16]};
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            started_reg <= 1'b0;
            side_reg    <= 1'b0;
            oval_reg    <= 1'b0;
            xacc_reg    <= '0;
            yacc_reg    <= '0;
            lacc_reg    <= '0;
            racc_reg    <= '0;
            head_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            started_reg <= started_next;
            side_reg    <= side_next;
            oval_reg    <= oval_next;
            xacc_reg    <= xacc_next;
            yacc_reg    <= yacc_next;
            lacc_reg    <= lacc_next;
            racc_reg    <= racc_next;
            head_reg    <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lsp_reg   <= lsp_next;
        rsp_reg   <= rsp_next;
        work_reg  <= work_next;
        dl_reg    <= dl_next;
        dr_reg    <= dr_next;
        odata_reg <= odata_next;
    end

    assign m_tvalid = oval_reg;
    assign m_tdata  = odata_reg;

    a_mul_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mul_start |-> !mul_st.busy)
        else $error("multiplier started while busy");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_st.busy)
        else $error("divider started while busy");

    a_trig_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (mul_start && state_reg == ST_X_MUL) |-> trig_valid)
        else $error("pose update used trig results before they were ready");

    a_take_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg != ST_IDLE))
        else $error("accepted beat did not start work");

endmodule

### sim/tb_top.sv
module tb_top;
    import odo_pkg::*;

    localparam int LIMIT = 4000000;
    localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ACC_LO = -ACC_HI - 1;

    typedef struct packed {
        logic        kind;
        logic [18:0] left_speed;
        logic [18:0] right_speed;
    } tick_t;

    typedef struct packed {
        logic [31:0] pos_x_um;
        logic [31:0] pos_y_um;
        logic [15:0] heading;
        logic [31:0] left_dist_um;
        logic [31:0] right_dist_um;
    } pose_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [39:0]  s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [143:0] m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [20:0]  cfg_data;

    tick_t  tick_q[$];
    pose_t  pose_q[$];
    int     errors;
    int     cycles;
    int     in_gap;
    int     out_gap;
    bit     hold_off;

    logic [19:0] period_r;
    logic [19:0] diameter_r;
    logic [20:0] base_r;
    logic        lrev_r;
    logic        rrev_r;
    longint      x_acc;
    longint      y_acc;
    longint      l_acc;
    longint      r_acc;
    logic [31:0] head_acc;

    diff_drive_odometry uut (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic longint div_rnd(longint num, longint den);
        longint q;
        q = ((num < 0 ? -num : num) + den / 2) / den;
        return num < 0 ? -q : q;
    endfunction

    function automatic longint asr(longint v, int k);
        return v >>> k;
    endfunction

    // Rounded a*b/2^31 with |a| < 2^45, |b| < 2^32, done on 128 bits.
    function automatic longint mul_q31(longint a, longint b);
        logic [127:0] ua;
        logic [127:0] ub;
        logic [127:0] p;
        bit neg;
        neg = (a < 0) != (b < 0);
        ua = 128'(a < 0 ? -a : a);
        ub = 128'(b < 0 ? -b : b);
        p = (ua * ub + (128'd1 << 30)) >> 31;
        return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function automatic longint sat48(longint a, longint d);
        longint s;
        s = a + d;
        if (s > ACC_HI)
            return ACC_HI;
        if (s < ACC_LO)
            return ACC_LO;
        return s;
    endfunction

    function automatic longint wheel_travel(logic [18:0] raw, logic rev);
        longint s;
        longint v;
        s = longint'($signed(raw));
        if (rev)
            s = -s;
        v = div_rnd(s * longint'(diameter_r) * 3294199, longint'(60) << 20);
        return div_rnd(v * longint'(period_r) * 256, 1000000);
    endfunction

    task automatic cordic(input logic [31:0] ang, output longint c, output longint s);
        logic [31:0] u;
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        bit flip;
        u = ang & ~((32'd1 << (32 - 16)) - 1);
        flip = (u[31:30] == 2'd1) || (u[31:30] == 2'd2);
        if (flip)
            u = u + 32'h8000_0000;
        x = 652032874;
        y = 0;
        z = longint'($signed(u));
        for (int i = 0; i < 16; i++)
        begin
            xs = asr(x, i);
            ys = asr(y, i);
            if (z >= 0)
            begin
                x -= ys; y += xs; z -= longint'(atan_at(i[4:0]));
            end
            else
            begin
                x += ys; y -= xs; z += longint'(atan_at(i[4:0]));
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic predict_pose(input tick_t t);
        longint dl;
        longint dr;
        longint c;
        longint s;
        longint dth;
        longint base;
        pose_t p;
        if (t.kind)
        begin
            x_acc = 0; y_acc = 0; l_acc = 0; r_acc = 0; head_acc = 0;
        end
        else
        begin
            dl = wheel_travel(t.left_speed, lrev_r);
            dr = wheel_travel(t.right_speed, rrev_r);
            base = base_r == 0 ? 1 : longint'(base_r);
            cordic(head_acc, c, s);
            l_acc = sat48(l_acc, dl);
            r_acc = sat48(r_acc, dr);
            x_acc = sat48(x_acc, mul_q31(dl + dr, c));
            y_acc = sat48(y_acc, mul_q31(dl + dr, s));
            dth = div_rnd((dr - dl) * 333772, base * 32);
            head_acc = head_acc + dth[31:0];
        end
        p.pos_x_um = 32'(asr(x_acc, 16));
        p.pos_y_um = 32'(asr(y_acc, 16));
        p.heading = head_acc[31:16];
        p.left_dist_um = 32'(asr(l_acc, 16));
        p.right_dist_um = 32'(asr(r_acc, 16));
        pose_q.push_back(p);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            in_gap   <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_pose(tick_q.pop_front());
            end
            if (s_tvalid && !s_tready)
            begin
            end
            else if (in_gap > 0)
            begin
                s_tvalid <= 1'b0;
                in_gap   <= in_gap - 1;
            end
            else if (s_tvalid && s_tready)
            begin
                s_tvalid <= 1'b0;
                in_gap   <= $urandom_range(0, 9);
            end
            else if (tick_q.size() > 0 && !(hold_off && pose_q.size() > 0))
            begin
                s_tvalid <= 1'b1;
                s_tuser  <= tick_q[0].kind;
                s_tdata  <= {2'b00, tick_q[0].right_speed, tick_q[0].left_speed};
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        pose_t got;
        pose_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            out_gap  <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = {m_tdata[143:128], m_tdata[127:96], m_tdata[95:64],
                       m_tdata[63:32], m_tdata[31:0]};
                got.pos_x_um = m_tdata[31:0];
                got.pos_y_um = m_tdata[63:32];
                got.heading = m_tdata[79:64];
                got.left_dist_um = m_tdata[111:80];
                got.right_dist_um = m_tdata[143:112];
                if (pose_q.size() == 0)
                begin
                    $error("unexpected result beat");
                    errors++;
                end
                else
                begin
                    want = pose_q.pop_front();
                    if (got.pos_x_um !== want.pos_x_um)
                    begin
                        $error("pos_x_um exp %0h got %0h", want.pos_x_um, got.pos_x_um);
                        errors++;
                    end
                    if (got.pos_y_um !== want.pos_y_um)
                    begin
                        $error("pos_y_um exp %0h got %0h", want.pos_y_um, got.pos_y_um);
                        errors++;
                    end
                    if (got.heading !== want.heading)
                    begin
                        $error("heading exp %0h got %0h", want.heading, got.heading);
                        errors++;
                    end
                    if (got.left_dist_um !== want.left_dist_um)
                    begin
                        $error("left_dist_um exp %0h got %0h", want.left_dist_um,
                               got.left_dist_um);
                        errors++;
                    end
                    if (got.right_dist_um !== want.right_dist_um)
                    begin
                        $error("right_dist_um exp %0h got %0h", want.right_dist_um,
                               got.right_dist_um);
                        errors++;
                    end
                end
            end
            if (out_gap > 0)
            begin
                m_tready <= 1'b0;
                out_gap  <= out_gap - 1;
            end
            else if (m_tvalid && m_tready)
            begin
                m_tready <= 1'b0;
                out_gap  <= $urandom_range(0, 9);
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic add_tick(logic kind, logic [18:0] l, logic [18:0] r);
        tick_t t;
        t.kind = kind;
        t.left_speed = l;
        t.right_speed = r;
        tick_q.push_back(t);
    endtask

    task automatic settle();
        wait (tick_q.size() == 0 && !s_tvalid && pose_q.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [20:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_PERIOD:   period_r = val[19:0];
            CFG_DIAMETER: diameter_r = val[19:0];
            CFG_BASE:     base_r = val;
            CFG_LREV:     lrev_r = val[0];
            CFG_RREV:     rrev_r = val[0];
            default:      ;
        endcase
    endtask

    task automatic random_ticks(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 40) == 0)
                add_tick(1'b1, 19'($urandom), 19'($urandom));
            else if ($urandom_range(0, 3) == 0)
                add_tick(1'b0, 19'($urandom), 19'($urandom));
            else
                add_tick(1'b0, 19'($urandom_range(0, 8191) - 4096),
                         19'($urandom_range(0, 8191) - 4096));
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        cycles = 0;
        hold_off = 1'b0;
        period_r = 20'd50000;
        diameter_r = 20'd65000;
        base_r = 21'd150000;
        lrev_r = 1'b1;
        rrev_r = 1'b0;
        x_acc = 0; y_acc = 0; l_acc = 0; r_acc = 0; head_acc = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        add_tick(1'b0, 19'h3FFFF, 19'h3FFFF);
        add_tick(1'b0, 19'h40000, 19'h40000);
        add_tick(1'b0, 19'h3FFFF, 19'h40000);
        add_tick(1'b0, 19'h0, 19'h0);
        add_tick(1'b0, 19'h7FFFF, 19'h1);
        add_tick(1'b1, 19'h55555, 19'h2AAAA);
        for (int i = 0; i < 8; i++)
            add_tick(1'b0, 19'h01000, 19'h3F000);
        settle();

        write_reg(CFG_PERIOD, 21'd1000000);
        write_reg(CFG_DIAMETER, 21'd1000000);
        write_reg(CFG_BASE, 21'd0);
        write_reg(CFG_LREV, 21'd0);
        write_reg(CFG_RREV, 21'd1);
        for (int i = 0; i < 12; i++)
            add_tick(1'b0, 19'h3FFFF, 19'h40000);
        add_tick(1'b0, 19'h0, 19'h3FFFF);
        hold_off = 1'b1;
        settle();
        hold_off = 1'b0;
        random_ticks(100);
        settle();

        write_reg(CFG_PERIOD, 21'd0);
        write_reg(CFG_DIAMETER, 21'd0);
        random_ticks(20);
        settle();

        write_reg(CFG_PERIOD, 21'd1);
        write_reg(CFG_DIAMETER, 21'd1000);
        write_reg(CFG_BASE, 21'd2000000);
        random_ticks(100);
        settle();

        write_reg(CFG_PERIOD, 21'h1FFFFF);
        write_reg(CFG_DIAMETER, 21'h1FFFFF);
        write_reg(CFG_BASE, 21'h1FFFFF);
        random_ticks(100);
        settle();

        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(CFG_PERIOD, 21'($urandom_range(1, 1000000)));
            write_reg(CFG_DIAMETER, 21'($urandom_range(1000, 1000000)));
            write_reg(CFG_BASE, 21'($urandom_range(1000, 2000000)));
            write_reg(CFG_LREV, 21'($urandom_range(0, 1)));
            write_reg(CFG_RREV, 21'($urandom_range(0, 1)));
            random_ticks(95);
            settle();
        end

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
